// ----- rtl/crccfh_pkg.sv -----
// ----------------------------------------------------------------------------
// crccfh_pkg
// Shared types, codes and the CRC-16/MODBUS byte step for the frame handler.
// ----------------------------------------------------------------------------
`default_nettype none

package crccfh_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  STATUS_RESET = 8'b1000_0000;

  // reply kinds
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // command codes
  localparam logic [7:0] CMD_BIT_FIRST = 8'h01;
  localparam logic [7:0] CMD_BIT_LAST  = 8'h0E;
  localparam logic [7:0] CMD_S1_CLR7   = 8'h0F;
  localparam logic [7:0] CMD_S1_SET7   = 8'h10;
  localparam logic [7:0] CMD_S2_CLR7   = 8'h11;
  localparam logic [7:0] CMD_S2_SET7   = 8'h12;
  localparam logic [7:0] CMD_QUERY     = 8'h13;
  localparam logic [7:0] CMD_STATUS    = 8'h1E;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] dest_address;
    logic [7:0] command;
    logic [7:0] data_low;
    logic [7:0] data_high;
    logic [7:0] check_low;
    logic [7:0] check_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0] reply_kind;
    logic [7:0] reply_byte0;
    logic [7:0] reply_byte1;
    logic [7:0] reply_byte2;
    logic [7:0] reply_byte3;
    logic [7:0] reply_byte4;
    logic [7:0] reply_byte5;
    logic [7:0] reply_byte6;
  } out_item_t;

  // One byte through the reflected CRC; the shift chain is linear and folds
  // into an xor tree.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/crccfh_in_if.sv -----
// ----------------------------------------------------------------------------
// crccfh_in_if
// Valid/ready channel carrying one command frame per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface crccfh_in_if
  import crccfh_pkg::*;
  ;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/crccfh_out_if.sv -----
// ----------------------------------------------------------------------------
// crccfh_out_if
// Valid/ready channel carrying one reply per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface crccfh_out_if
  import crccfh_pkg::*;
  ;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/crccfh_crc_check.sv -----
// ----------------------------------------------------------------------------
// crccfh_crc_check
// CRC-16/MODBUS over five frame bytes plus a zero byte, compared to the
// received check value.
// ----------------------------------------------------------------------------
`default_nettype none

module crccfh_crc_check
  import crccfh_pkg::*;
(
  input  wire in_item_t frame,
  output logic          crc_ok
);

  logic [15:0] c0, c1, c2, c3, c4, c5;

  always_comb begin
    c0 = crc_byte(CRC_INIT, frame.start_byte);
    c1 = crc_byte(c0, frame.dest_address);
    c2 = crc_byte(c1, frame.command);
    c3 = crc_byte(c2, frame.data_low);
    c4 = crc_byte(c3, frame.data_high);
    c5 = crc_byte(c4, 8'h00);
    crc_ok = (c5 == {frame.check_high, frame.check_low});
  end

endmodule

`default_nettype wire

// ----- rtl/crc_checked_command_frame_handler_unit.sv -----
// ----------------------------------------------------------------------------
// crc_checked_command_frame_handler_unit
// Checks a seven-byte command frame, updates the status registers and replies.
// ----------------------------------------------------------------------------
// One frame is taken per transaction and one frame can be taken every cycle
// while the output is not stalled. A frame sits in an input register while
// its CRC is checked and its command decoded; its reply (if any) is loaded
// into the result register when the frame leaves the input register, and is
// offered from there until the output takes it. Status bits change in frame
// order as each frame leaves the input register. A CRC mismatch gives an
// error reply with all bytes zero; unknown commands give no reply. Both status
// registers reset to 0x80.
`default_nettype none

module crc_checked_command_frame_handler_unit
  import crccfh_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  crccfh_in_if.sink     in_chan,
  crccfh_out_if.source  out_chan
);

  in_item_t  item_r;
  logic      item_vld_r, item_vld_nxt;
  out_item_t res_r, res_nxt;
  logic      res_vld_r, res_vld_nxt;
  logic [7:0] status1_r, status1_nxt;
  logic [7:0] status2_r, status2_nxt;

  logic       crc_ok;
  logic       known;
  logic       res_free;
  logic       advance;
  logic [2:0] bit_pos;

  crccfh_crc_check u_crc (
    .frame  (item_r),
    .crc_ok (crc_ok)
  );

  assign res_free       = !res_vld_r || out_chan.ready;
  assign advance        = item_vld_r && res_free;
  assign in_chan.ready  = !item_vld_r || res_free;
  assign out_chan.valid = res_vld_r;
  assign out_chan.data  = res_r;
  assign bit_pos        = 3'((item_r.command - 8'd1) >> 1);

  always_comb begin
    status1_nxt = status1_r;
    status2_nxt = status2_r;
    known       = 1'b1;
    res_nxt.reply_kind  = KIND_ECHO;
    res_nxt.reply_byte0 = item_r.start_byte;
    res_nxt.reply_byte1 = item_r.dest_address;
    res_nxt.reply_byte2 = item_r.command;
    res_nxt.reply_byte3 = item_r.data_low;
    res_nxt.reply_byte4 = item_r.data_high;
    res_nxt.reply_byte5 = item_r.check_low;
    res_nxt.reply_byte6 = item_r.check_high;

    if (item_r.command >= CMD_BIT_FIRST && item_r.command <= CMD_BIT_LAST) begin
      // odd codes set, even codes clear
      status1_nxt[bit_pos] = item_r.command[0];
    end else begin
      case (item_r.command)
        CMD_S1_CLR7: status1_nxt[7] = 1'b0;
        CMD_S1_SET7: status1_nxt[7] = 1'b1;
        CMD_S2_CLR7: status2_nxt[7] = 1'b0;
        CMD_S2_SET7: status2_nxt[7] = 1'b1;
        CMD_QUERY:   known = 1'b1;
        CMD_STATUS: begin
          res_nxt.reply_kind  = KIND_STATUS;
          res_nxt.reply_byte3 = status1_r;
          res_nxt.reply_byte4 = status2_r;
        end
        default:     known = 1'b0;
      endcase
    end

    if (!crc_ok) begin
      // drop the update and report the mismatch
      status1_nxt = status1_r;
      status2_nxt = status2_r;
      known       = 1'b1;
      res_nxt     = '0;
      res_nxt.reply_kind = KIND_ERROR;
    end

    if (!advance) begin
      status1_nxt = status1_r;
      status2_nxt = status2_r;
    end
  end

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_chan.valid && in_chan.ready) begin
      item_vld_nxt = 1'b1;
    end else if (advance) begin
      item_vld_nxt = 1'b0;
    end

    res_vld_nxt = res_vld_r;
    if (advance) begin
      res_vld_nxt = known;
    end else if (out_chan.ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      status1_r  <= STATUS_RESET;
      status2_r  <= STATUS_RESET;
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
      status1_r  <= status1_nxt;
      status2_r  <= status2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r <= in_chan.data;
    end
    if (advance && known) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sim/crc_checked_command_frame_handler_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_command_frame_handler_unit_tb
// Drives command frames into the frame handler and checks every reply against
// a bit-level CRC-16/MODBUS predictor with its own copy of both status
// registers, or against the row's reply for typed rows. The directed table
// comes first. Random traffic follows, mostly well-formed frames, under three
// idle patterns, one long output hold-off and drains between phases.
// ----------------------------------------------------------------------------

module crc_checked_command_frame_handler_unit_tb;
  import crccfh_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int HOLD_OFF_CYCLES = 160;
  localparam int TAIL_CYCLES = 8;

  // codes that select nothing
  localparam logic [7:0] CMD_NONE_LOW  = 8'h00;
  localparam logic [7:0] CMD_NONE_HIGH = 8'hFF;
  localparam logic [7:0] CMD_NONE_GAP  = 8'h14;
  localparam logic [7:0] CMD_NONE_NEXT = 8'h1F;

  typedef struct {
    logic [7:0]  start_byte;
    logic [7:0]  dest_address;
    logic [7:0]  command;
    logic [7:0]  data_low;
    logic [7:0]  data_high;
    logic [15:0] spoil;     // xor into the sealed check value
    bit          typed;
    bit          silent;
    logic [1:0]  kind;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
  } frame_row_t;

  typedef struct {
    bit        typed;
    bit        silent;
    out_item_t reply;
  } typed_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  crccfh_in_if  in_bus ();
  crccfh_out_if out_bus ();

  crc_checked_command_frame_handler_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always #4 clk = ~clk;

  logic [7:0]   status_one_q = STATUS_RESET;
  logic [7:0]   status_two_q = STATUS_RESET;
  out_item_t    reply_q[$];
  typed_reply_t typed_q[$];
  frame_row_t   frame_plan[23];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ready_hold_left = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  function automatic logic [7:0] bit_cmd(input int pos, input bit set_it);
    return CMD_BIT_FIRST + 8'(2 * pos) + (set_it ? 8'd0 : 8'd1);
  endfunction

  // Reflected CRC one bit at a time over five frame bytes and a zero pad byte.
  function automatic logic [15:0] modbus_crc(input in_item_t f);
    logic [47:0] stream;
    logic [15:0] crc;
    logic        fb;
    stream = {f.start_byte, f.dest_address, f.command, f.data_low, f.data_high, 8'h00};
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      for (int b = 0; b < 8; b++) begin
        fb = crc[0] ^ stream[47 - 8 * i - 7 + b];
        crc = crc >> 1;
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

  function automatic in_item_t seal_frame(input in_item_t f, input logic [15:0] spoil);
    logic [15:0] crc;
    crc = modbus_crc(f) ^ spoil;
    f.check_low = crc[7:0];
    f.check_high = crc[15:8];
    return f;
  endfunction

  function automatic void predict_reply(input in_item_t f, output out_item_t r,
                                        output bit has_reply);
    logic [7:0] offset;
    has_reply = 1'b1;
    r = {KIND_ECHO, f.start_byte, f.dest_address, f.command, f.data_low, f.data_high,
         f.check_low, f.check_high};
    if ({f.check_high, f.check_low} != modbus_crc(f)) begin
      r = '0;
      r.reply_kind = KIND_ERROR;
    end else if (f.command >= CMD_BIT_FIRST && f.command <= CMD_BIT_LAST) begin
      offset = f.command - CMD_BIT_FIRST;
      status_one_q[offset[3:1]] = f.command[0];
    end else if (f.command == CMD_S1_CLR7) begin
      status_one_q[7] = 1'b0;
    end else if (f.command == CMD_S1_SET7) begin
      status_one_q[7] = 1'b1;
    end else if (f.command == CMD_S2_CLR7) begin
      status_two_q[7] = 1'b0;
    end else if (f.command == CMD_S2_SET7) begin
      status_two_q[7] = 1'b1;
    end else if (f.command == CMD_STATUS) begin
      r.reply_kind = KIND_STATUS;
      r.reply_byte3 = status_one_q;
      r.reply_byte4 = status_two_q;
    end else if (f.command != CMD_QUERY) begin
      has_reply = 1'b0;
    end
  endfunction

  function automatic in_item_t random_frame();
    in_item_t f;
    int       pick;
    f = 56'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 95) begin
      if ($urandom_range(99) < 70) begin
        f.command = 8'($urandom_range(31));
      end
      // mostly well-formed, some with a damaged check value
      f = seal_frame(f, (pick < 80) ? 16'h0000 : 16'($urandom_range(65535, 1)));
    end
    return f;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch on %s: got %02h, want %02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Hold valid until the transaction goes through; return just after a falling edge.
  task automatic offer_frame(input in_item_t f, input typed_reply_t note);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    typed_q.push_back(note);
    in_bus.valid <= 1'b1;
    in_bus.data <= f;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_bus.valid <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int count);
    typed_reply_t note;
    note = '{typed: 1'b0, silent: 1'b0, reply: '0};
    for (int n = 0; n < count; n++) begin
      offer_frame(random_frame(), note);
    end
  endtask

  always @(negedge clk) begin
    if (ready_hold_left > 0) begin
      out_bus.ready <= 1'b0;
      ready_hold_left <= ready_hold_left - 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare replies first, then predict for the frame taken at the same edge.
  always @(posedge clk) begin : reply_check
    out_item_t    got;
    out_item_t    want;
    typed_reply_t note;
    bit           has_reply;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got = out_bus.data;
        if (reply_q.size() == 0) begin
          report_mismatch("reply with nothing outstanding", 8'(got.reply_kind), 8'h00);
        end else begin
          want = reply_q.pop_front();
          if (got.reply_kind != want.reply_kind) begin
            report_mismatch("reply_kind", 8'(got.reply_kind), 8'(want.reply_kind));
          end
          for (int i = 0; i < 7; i++) begin
            if (got[55 - 8 * i -: 8] !== want[55 - 8 * i -: 8]) begin
              report_mismatch($sformatf("reply_byte%0d", i), got[55 - 8 * i -: 8],
                              want[55 - 8 * i -: 8]);
            end
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        note = typed_q.pop_front();
        predict_reply(in_bus.data, want, has_reply);
        if (note.typed) begin
          has_reply = !note.silent;
          want = note.reply;
        end
        if (has_reply) begin
          reply_q.push_back(want);
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_item_t     f;
    typed_reply_t note;
    frame_row_t   row;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    out_bus.ready = 1'b0;

    frame_plan = '{
      // status right after reset, unknown codes at both ends, bad check values
      '{8'h00, 8'h00, CMD_STATUS,    8'h00, 8'h00, 16'h0000, 1, 0, KIND_STATUS,
        STATUS_RESET, STATUS_RESET},
      '{8'hFF, 8'hFF, CMD_NONE_HIGH, 8'hFF, 8'hFF, 16'h0000, 1, 1, KIND_ECHO, 0, 0},
      '{8'h00, 8'h00, CMD_NONE_LOW,  8'h00, 8'h00, 16'h0000, 1, 1, KIND_ECHO, 0, 0},
      '{8'h00, 8'h00, CMD_QUERY,     8'h00, 8'h00, 16'h0001, 1, 0, KIND_ERROR, 0, 0},
      '{8'hFF, 8'hFF, CMD_S1_SET7,   8'hFF, 8'hFF, 16'h8000, 1, 0, KIND_ERROR, 0, 0},
      '{8'h3A, 8'h7F, CMD_BIT_FIRST, 8'h55, 8'hAA, 16'hFFFF, 1, 0, KIND_ERROR, 0, 0},
      // bit updates and queries, predicted; two unknown codes, typed as silent
      '{8'h01, 8'h80, bit_cmd(0, 1), 8'hFF, 8'hFF, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h02, 8'h40, bit_cmd(0, 0), 8'h00, 8'hFF, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h03, 8'h20, bit_cmd(6, 1), 8'hFF, 8'h00, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h04, 8'h10, CMD_STATUS,    8'h12, 8'h34, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h05, 8'h08, CMD_BIT_LAST,  8'hA5, 8'h5A, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h06, 8'h04, CMD_S1_CLR7,   8'h0F, 8'hF0, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h07, 8'h02, CMD_S2_CLR7,   8'h80, 8'h01, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h08, 8'h01, CMD_STATUS,    8'hFF, 8'hFF, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h09, 8'hFE, CMD_S1_SET7,   8'h11, 8'h22, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h0A, 8'hFD, CMD_S2_SET7,   8'h33, 8'h44, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h0B, 8'hFB, CMD_QUERY,     8'h66, 8'h77, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h0C, 8'hF7, CMD_NONE_NEXT, 8'h88, 8'h99, 16'h0000, 1, 1, KIND_ECHO, 0, 0},
      '{8'h0D, 8'hEF, CMD_NONE_GAP,  8'hAA, 8'hBB, 16'h0000, 1, 1, KIND_ECHO, 0, 0},
      '{8'h0E, 8'hDF, bit_cmd(2, 1), 8'hCC, 8'hDD, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h0F, 8'hBF, bit_cmd(4, 0), 8'hEE, 8'h01, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'h10, 8'h7F, bit_cmd(3, 0), 8'h02, 8'h03, 16'h0000, 0, 0, KIND_ECHO, 0, 0},
      '{8'hAA, 8'h55, CMD_STATUS,    8'h00, 8'h00, 16'h0000, 0, 0, KIND_ECHO, 0, 0}
    };

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 6;
    recv_idle_pct = 74;
    foreach (frame_plan[i]) begin
      row = frame_plan[i];
      f = seal_frame({row.start_byte, row.dest_address, row.command, row.data_low,
                      row.data_high, 16'h0000}, row.spoil);
      note.typed = row.typed;
      note.silent = row.silent;
      if (row.kind == KIND_ERROR) begin
        note.reply = '0;
        note.reply.reply_kind = KIND_ERROR;
      end else begin
        note.reply = {row.kind, f.start_byte, f.dest_address, f.command, row.byte3,
                      row.byte4, f.check_low, f.check_high};
      end
      offer_frame(f, note);
    end
    drain_replies();

    random_phase(RANDOM_PER_PHASE);
    drain_replies();

    send_idle_pct = 74;
    recv_idle_pct = 6;
    random_phase(RANDOM_PER_PHASE);
    drain_replies();

    // hold the output off while frames keep coming, so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    ready_hold_left = HOLD_OFF_CYCLES;
    random_phase(RANDOM_PER_PHASE);

    drain_replies();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
